@@ design/sis_pkg.sv @@
// ----------------------------------------------------------------------------
// sis_pkg: shared types and constants of the sorted integer set
// Sizes, operation and status codes, transfer payloads and the command and
// flag structs passed along the cell chain.
// ----------------------------------------------------------------------------
package sis_pkg;

    localparam int CAPACITY = 64;
    localparam int VALUE_W  = 32;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;
    // internal entry count, wide enough to hold CAPACITY itself
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic [MODE_W-1:0] {
        MODE_SEARCH = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_REMOVE = 2'd2
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_ABSENT  = 2'd1,
        STATUS_PRESENT = 2'd2,
        STATUS_FULL    = 2'd3
    } status_t;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic signed [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } rsp_t;

    // broadcast to every cell
    typedef struct packed {
        logic                      ins_en;
        logic                      rem_en;
        logic signed [VALUE_W-1:0] key;
    } cell_cmd_t;

    // compare results of one cell
    typedef struct packed {
        logic lt;
        logic eq;
    } cell_flags_t;

endpackage

@@ design/sis_cell.sv @@
// ----------------------------------------------------------------------------
// sis_cell: one entry of the sorted chain
// Holds one value, compares it with the broadcast key and, on an insert or
// remove, takes its value from the neighbor below or above.
// ----------------------------------------------------------------------------
module sis_cell (
    input  logic                               aclk,
    input  sis_pkg::cell_cmd_t                 cmd,
    input  logic                               occupied,
    input  logic signed [sis_pkg::VALUE_W-1:0] prev_value,
    input  logic                               prev_lt,
    input  logic signed [sis_pkg::VALUE_W-1:0] next_value,
    output logic signed [sis_pkg::VALUE_W-1:0] value,
    output sis_pkg::cell_flags_t               flags
);
    import sis_pkg::*;

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;

    // compare against key; empty cells never match
    assign flags.lt = occupied && (value_reg < cmd.key);
    assign flags.eq = occupied && (value_reg == cmd.key);
    assign value    = value_reg;

    // insert: first cell not below key takes key, later ones shift up
    // remove: from the matching cell on, shift down
    always_comb begin
        value_next = value_reg;
        if (cmd.ins_en && !flags.lt) begin
            value_next = prev_lt ? cmd.key : prev_value;
        end else if (cmd.rem_en && !flags.lt) begin
            value_next = next_value;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

endmodule

@@ design/sorted_integer_set_top.sv @@
// ----------------------------------------------------------------------------
// sorted_integer_set_top: sorted set of distinct signed 32-bit integers
// Search, insert or remove one value per request; a chain of cells holds the
// entries in ascending order and shifts them in one step.
//
//   port group | dir | payload | meaning
//   s_*        | in  | req_t   | mode (search/insert/remove) and value
//   m_*        | out | rsp_t   | status and entry count after the operation
//
// A request is accepted in ST_IDLE; in ST_EXEC all cells compare with the
// key and shift, which also loads the result register.
// The execute step waits while an earlier result is still held on m_*;
// a new request is accepted as soon as the previous one has executed.
// Reset clears the entry count; cell contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_integer_set_top (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  sis_pkg::req_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output sis_pkg::rsp_t m_data
);
    import sis_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t           state_reg, state_next;
    req_t             op_reg, op_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_valid_reg, m_valid_next;
    rsp_t             m_data_reg, m_data_next;

    cell_cmd_t                 cmd;
    logic signed [VALUE_W-1:0] cell_value [CAPACITY];
    cell_flags_t               cell_flags [CAPACITY];
    logic [CAPACITY-1:0]       lt_vec;
    logic [CAPACITY-1:0]       eq_vec;
    logic [CAPACITY-1:0]       occ_vec;

    logic    hit;
    logic    full;
    logic    exec_fire;
    status_t status;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // execute once the result register is free
    assign exec_fire = (state_reg == ST_EXEC) && (!m_valid_reg || m_ready);
    assign hit       = |eq_vec;
    assign full      = (count_reg == CNT_W'(CAPACITY));

    assign cmd.key    = op_reg.value;
    assign cmd.ins_en = exec_fire && (op_reg.mode == MODE_INSERT) && !hit && !full;
    assign cmd.rem_en = exec_fire && (op_reg.mode == MODE_REMOVE) && hit;

    // cell chain
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [VALUE_W-1:0] prev_v;
        logic signed [VALUE_W-1:0] next_v;
        logic                      prev_l;

        assign occ_vec[i] = (CNT_W'(i) < count_reg);
        assign lt_vec[i]  = cell_flags[i].lt;
        assign eq_vec[i]  = cell_flags[i].eq;

        if (i == 0) begin : g_head
            assign prev_v = op_reg.value;
            assign prev_l = 1'b0;
        end else begin : g_body
            assign prev_v = cell_value[i-1];
            assign prev_l = lt_vec[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign next_v = op_reg.value;
        end else begin : g_inner
            assign next_v = cell_value[i+1];
        end

        sis_cell u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .occupied   (occ_vec[i]),
            .prev_value (prev_v),
            .prev_lt    (prev_l),
            .next_value (next_v),
            .value      (cell_value[i]),
            .flags      (cell_flags[i])
        );
    end

    // status of the executing request
    always_comb begin
        case (op_reg.mode)
            MODE_SEARCH: status = hit ? STATUS_OK : STATUS_ABSENT;
            MODE_INSERT: begin
                if (hit) begin
                    status = STATUS_PRESENT;
                end else if (full) begin
                    status = STATUS_FULL;
                end else begin
                    status = STATUS_OK;
                end
            end
            MODE_REMOVE: status = hit ? STATUS_OK : STATUS_ABSENT;
            default:     status = STATUS_OK;
        endcase
    end

    // next-state and result logic
    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next    = s_data;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (exec_fire) begin
                    if (cmd.ins_en) begin
                        count_next = count_reg + CNT_W'(1);
                    end else if (cmd.rem_en) begin
                        count_next = count_reg - CNT_W'(1);
                    end
                    m_valid_next       = 1'b1;
                    m_data_next.status = status;
                    m_data_next.count  = COUNT_W'(count_next);
                    state_next         = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg     <= op_next;
        m_data_reg <= m_data_next;
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !exec_fire |=> $stable(count_reg))
        else $error("entry count changed without an executed request");

    a_search_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        exec_fire && (op_reg.mode == MODE_SEARCH) |=> $stable(count_reg))
        else $error("search changed the entry count");

    a_rsp_count: assert property (@(posedge aclk) disable iff (!aresetn)
        exec_fire |=> m_valid && (m_data.count == COUNT_W'(count_reg)))
        else $error("reported count differs from held count");

    a_one_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(eq_vec))
        else $error("key matches more than one entry");

endmodule

@@ bench/tb_sorted_integer_set_top.sv @@
// ----------------------------------------------------------------------------
// tb_sorted_integer_set_top: self-checking bench of the sorted integer set
// Drives search, insert and remove requests through the s_* channel and
// checks every m_* transfer against a queue-based model of the ordered set.
// A short table of directed rows covers the edges of the value range, each
// operation, the head entry and the unused mode. Random traffic follows, in
// fill, mixed and drain segments, so the set runs full and empty repeatedly.
// Both sides idle at random; the sink holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_sorted_integer_set_top;

    import sis_pkg::*;

    localparam logic [MODE_W-1:0]         MODE_UNUSED      = 2'd3;
    localparam logic signed [VALUE_W-1:0] VAL_MIN          = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX          = 32'sh7fff_ffff;
    localparam int                        DIRECTED_ITEMS   = 21;
    localparam int                        RANDOM_ITEMS     = 1400;
    localparam int                        SEGMENT_ITEMS    = 200;
    localparam int                        PAUSE_AT         = DIRECTED_ITEMS + 700;
    localparam int                        LONG_HOLD_AT     = 500;
    localparam int                        LONG_HOLD_CYCLES = 200;
    localparam int                        DRAIN_CYCLES     = 20;
    localparam int                        WATCHDOG_LIMIT   = 2000;
    localparam int                        MAX_REPORTS      = 10;

    // one directed row; has_rsp marks an expectation typed in by hand
    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [VALUE_W-1:0]  value;
        logic                has_rsp;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } directed_row_t;

    logic  aclk = 1'b0;
    logic  aresetn;
    logic  s_valid;
    logic  s_ready;
    req_t  s_data;
    logic  m_valid;
    logic  m_ready;
    rsp_t  m_data;

    // model state and pending results
    logic signed [VALUE_W-1:0] held_vals[$];
    rsp_t                      pending_rsp[$];
    int unsigned               mismatches   = 0;
    int unsigned               quiet_cycles = 0;

    directed_row_t directed_rows [DIRECTED_ITEMS] = '{
        '{MODE_SEARCH, 32'sd0,           1'b1, STATUS_ABSENT,  7'd0},
        '{MODE_REMOVE, 32'sd0,           1'b1, STATUS_ABSENT,  7'd0},
        '{MODE_UNUSED, 32'sd7,           1'b1, STATUS_OK,      7'd0},
        '{MODE_INSERT, VAL_MAX,          1'b1, STATUS_OK,      7'd1},
        // duplicate of the only entry is reported, not appended
        '{MODE_INSERT, VAL_MAX,          1'b1, STATUS_PRESENT, 7'd1},
        '{MODE_SEARCH, VAL_MAX,          1'b1, STATUS_OK,      7'd1},
        // lands ahead of the head
        '{MODE_INSERT, VAL_MIN,          1'b1, STATUS_OK,      7'd2},
        '{MODE_INSERT, 32'sd0,           1'b1, STATUS_OK,      7'd3},
        '{MODE_INSERT, -32'sd1,          1'b1, STATUS_OK,      7'd4},
        '{MODE_INSERT, 32'sd1,           1'b1, STATUS_OK,      7'd5},
        '{MODE_SEARCH, -32'sd1,          1'b1, STATUS_OK,      7'd5},
        '{MODE_SEARCH, 32'sd2,           1'b1, STATUS_ABSENT,  7'd5},
        // take out the head entry
        '{MODE_REMOVE, VAL_MIN,          1'b1, STATUS_OK,      7'd4},
        '{MODE_SEARCH, VAL_MIN,          1'b1, STATUS_ABSENT,  7'd4},
        '{MODE_REMOVE, VAL_MIN,          1'b1, STATUS_ABSENT,  7'd4},
        '{MODE_INSERT, 32'sh5555_5555,   1'b0, STATUS_OK,      7'd0},
        '{MODE_INSERT, 32'shAAAA_AAAA,   1'b0, STATUS_OK,      7'd0},
        '{MODE_REMOVE, 32'sd0,           1'b0, STATUS_OK,      7'd0},
        '{MODE_UNUSED, -32'sd1,          1'b0, STATUS_OK,      7'd0},
        '{MODE_REMOVE, VAL_MAX,          1'b0, STATUS_OK,      7'd0},
        '{MODE_INSERT, VAL_MIN + 32'sd1, 1'b0, STATUS_OK,      7'd0}
    };

    sorted_integer_set_top i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // clock: period 12
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // reset asserted at start, then released
    initial begin
        aresetn <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // apply one operation to the model set, return the status and count
    function automatic rsp_t apply_op(req_t op);
        logic signed [VALUE_W-1:0] key;
        int                        pos;
        logic                      hit;
        rsp_t                      res;
        key = op.value;
        pos = 0;
        while (pos < held_vals.size() && held_vals[pos] < key)
            pos++;
        hit        = (pos < held_vals.size()) && (held_vals[pos] == key);
        res.status = STATUS_OK;
        case (op.mode)
            MODE_SEARCH: begin
                if (!hit)
                    res.status = STATUS_ABSENT;
            end
            MODE_INSERT: begin
                // duplicate check comes ahead of the full check
                if (hit)
                    res.status = STATUS_PRESENT;
                else if (held_vals.size() >= CAPACITY)
                    res.status = STATUS_FULL;
                else
                    held_vals.insert(pos, key);
            end
            MODE_REMOVE: begin
                if (!hit)
                    res.status = STATUS_ABSENT;
                else
                    held_vals.delete(pos);
            end
            default: ;
        endcase
        res.count = COUNT_W'(held_vals.size());
        return res;
    endfunction

    // mostly a small pool so hits are common; some full-range and edge values
    function automatic logic signed [VALUE_W-1:0] random_value();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return int'($urandom_range(0, 80)) - 40;
        else if (pick < 90)
            return $urandom;
        case ($urandom_range(0, 3))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return 32'sd0;
            default: return -32'sd1;
        endcase
    endfunction

    // segments cycle through fill, mixed and drain mixes of operations
    function automatic req_t random_request(int idx);
        int unsigned seg;
        int unsigned pick;
        int unsigned ins_lim;
        int unsigned srch_lim;
        req_t        op;
        seg  = (idx / SEGMENT_ITEMS) % 3;
        pick = $urandom_range(0, 99);
        case (seg)
            0:       begin ins_lim = 88; srch_lim = 95; end
            1:       begin ins_lim = 40; srch_lim = 70; end
            default: begin ins_lim = 20; srch_lim = 35; end
        endcase
        if (pick < 3)
            op.mode = MODE_UNUSED;
        else if (pick < ins_lim)
            op.mode = MODE_INSERT;
        else if (pick < srch_lim)
            op.mode = MODE_SEARCH;
        else
            op.mode = MODE_REMOVE;
        op.value = random_value();
        return op;
    endfunction

    task automatic note_mismatch(string what, longint exp_val, longint act_val);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch %s: expected %0d, got %0d", what, exp_val, act_val);
    endtask

    // request source
    initial begin : request_source
        req_t        op_list[$];
        logic        typed_list[$];
        rsp_t        typed_rsp[$];
        req_t        op;
        rsp_t        res;
        int unsigned gap;
        logic        pause;
        int          idx;
        s_valid <= 1'b0;
        s_data  <= '0;

        for (idx = 0; idx < DIRECTED_ITEMS; idx++) begin
            op.mode  = directed_rows[idx].mode;
            op.value = directed_rows[idx].value;
            res.status = directed_rows[idx].status;
            res.count  = directed_rows[idx].count;
            op_list.push_back(op);
            typed_list.push_back(directed_rows[idx].has_rsp);
            typed_rsp.push_back(res);
        end
        for (idx = 0; idx < RANDOM_ITEMS; idx++) begin
            op_list.push_back(random_request(idx));
            typed_list.push_back(1'b0);
            typed_rsp.push_back('0);
        end

        wait (aresetn);
        @(posedge aclk);
        for (idx = 0; idx < op_list.size(); idx++) begin
            // idle gap before the item; every fourth block of 50 runs back to back
            gap   = (((idx / 50) % 4) == 3) ? 0 : $urandom_range(0, 9);
            pause = (idx == PAUSE_AT);
            if (pause && gap == 0)
                gap = 1;
            if (gap != 0) begin
                s_valid <= 1'b0;
                if (pause) begin
                    while (pending_rsp.size() != 0)
                        @(posedge aclk);
                end
                repeat (gap) @(posedge aclk);
            end
            s_valid <= 1'b1;
            s_data  <= op_list[idx];
            do
                @(posedge aclk);
            while (!(s_valid && s_ready));
            // transfer accepted: update the model and queue the result
            res = apply_op(op_list[idx]);
            if (typed_list[idx])
                pending_rsp.push_back(typed_rsp[idx]);
            else
                pending_rsp.push_back(res);
        end
        s_valid <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_rsp.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // result sink with random back-pressure and one long hold-off
    initial begin : result_sink
        int unsigned gap;
        int unsigned taken;
        logic        held_once;
        m_ready <= 1'b0;
        taken     = 0;
        held_once = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (!held_once && taken == LONG_HOLD_AT) begin
                held_once = 1'b1;
                gap       = LONG_HOLD_CYCLES;
            end else begin
                gap = (((taken / 50) % 4) == 1) ? 0 : $urandom_range(0, 9);
            end
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do
                @(posedge aclk);
            while (!(m_valid && m_ready));
            taken++;
        end
    end

    // compare each result transfer with the oldest pending one
    always @(posedge aclk) begin
        rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_rsp.size() == 0) begin
                note_mismatch("unexpected result, status", -1, m_data.status);
            end else begin
                want = pending_rsp.pop_front();
                if (m_data.status !== want.status)
                    note_mismatch("status", want.status, m_data.status);
                if (m_data.count !== want.count)
                    note_mismatch("count", want.count, m_data.count);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

endmodule
